// ----- design/shamd_pkg.sv -----
`default_nettype none
package shamd_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam logic [5:0]  LenFill    = 6'd56;

  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_PAD,
    SRC_ZERO,
    SRC_LEN
  } byte_src_e;

  // Controller to datapath
  typedef struct packed {
    logic       shift_en;
    logic       count_en;
    byte_src_e  src;
    logic       vars_load;
    logic       round_en;
    logic       hash_add;
    logic       hash_init;
    logic [1:0] word_idx;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fill_full;
    logic fill_len;
    logic round_last;
  } sts_t;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage
`default_nettype wire

// ----- design/shamd_dpath.sv -----
`default_nettype none
module shamd_dpath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [7:0]        data_byte_i,
  input  wire shamd_pkg::cmd_t   cmd_i,
  output shamd_pkg::sts_t        sts_o,
  output logic [63:0]            digest_word_o
);

  // Message window: 64 bytes while filling, 16 rolling words while compressing
  logic [511:0] msg_q, msg_d;
  logic [5:0]   fill_q;
  logic [60:0]  count_q;
  logic [5:0]   rnd_q;
  logic [31:0]  hash_q [8];
  logic [31:0]  vars_q [8];

  logic [63:0]  len_bits;
  logic [63:0]  len_shift;
  logic [7:0]   byte_in;
  logic [31:0]  w0, w1, w9, w14, w_new;
  logic [31:0]  t1, t2;
  logic [2:0]   hi_sel;

  function automatic logic [31:0] ssig0_w(input logic [31:0] x);
    return shamd_pkg::ssig0(x);
  endfunction

  function automatic logic [31:0] ssig1_w(input logic [31:0] x);
    return shamd_pkg::ssig1(x);
  endfunction

  assign w0  = msg_q[511:480];
  assign w1  = msg_q[479:448];
  assign w9  = msg_q[223:192];
  assign w14 = msg_q[63:32];
  assign w_new = ssig1_w(w14) + w9 + ssig0_w(w1) + w0;

  assign len_bits  = {count_q, 3'b000};
  assign len_shift = len_bits >> {~fill_q[2:0], 3'b000};

  always_comb begin
    case (cmd_i.src)
      shamd_pkg::SRC_DATA: byte_in = data_byte_i;
      shamd_pkg::SRC_PAD:  byte_in = 8'h80;
      shamd_pkg::SRC_ZERO: byte_in = 8'h00;
      shamd_pkg::SRC_LEN:  byte_in = len_shift[7:0];
      default:             byte_in = 8'h00;
    endcase
  end

  always_comb begin
    msg_d = msg_q;
    if (cmd_i.round_en) begin
      msg_d = {msg_q[479:0], w_new};
    end else if (cmd_i.shift_en) begin
      msg_d = {msg_q[503:0], byte_in};
    end
  end

  assign t1 = vars_q[7] + shamd_pkg::bsig1(vars_q[4])
            + ((vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]))
            + shamd_pkg::RoundK[rnd_q] + w0;
  assign t2 = shamd_pkg::bsig0(vars_q[0])
            + ((vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2])
               ^ (vars_q[1] & vars_q[2]));

  always_ff @(posedge clk_i) begin
    msg_q <= msg_d;
    if (cmd_i.round_en) begin
      vars_q[7] <= vars_q[6];
      vars_q[6] <= vars_q[5];
      vars_q[5] <= vars_q[4];
      vars_q[4] <= vars_q[3] + t1;
      vars_q[3] <= vars_q[2];
      vars_q[2] <= vars_q[1];
      vars_q[1] <= vars_q[0];
      vars_q[0] <= t1 + t2;
    end else if (cmd_i.vars_load) begin
      vars_q <= hash_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      count_q <= '0;
      rnd_q   <= '0;
      hash_q  <= shamd_pkg::InitHash;
    end else begin
      if (cmd_i.shift_en) begin
        fill_q <= fill_q + 6'd1;
      end
      if (cmd_i.round_en) begin
        rnd_q <= rnd_q + 6'd1;
      end
      if (cmd_i.hash_init) begin
        hash_q  <= shamd_pkg::InitHash;
        count_q <= '0;
      end else begin
        if (cmd_i.count_en) begin
          count_q <= count_q + 61'd1;
        end
        if (cmd_i.hash_add) begin
          for (int i = 0; i < 8; i++) begin
            hash_q[i] <= hash_q[i] + vars_q[i];
          end
        end
      end
    end
  end

  assign sts_o.fill_full  = (fill_q == 6'(shamd_pkg::BlockBytes - 1));
  assign sts_o.fill_len   = (fill_q == shamd_pkg::LenFill);
  assign sts_o.round_last = (rnd_q == 6'(shamd_pkg::Rounds - 1));

  assign hi_sel = {cmd_i.word_idx, 1'b0};
  assign digest_word_o = {hash_q[hi_sel], hash_q[hi_sel | 3'd1]};

endmodule
`default_nettype wire

// ----- design/shamd_ctrl.sv -----
`default_nettype none
module shamd_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic            byte_valid_i,
  input  wire logic            last_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [1:0]           word_index_o,
  output logic                 last_word_o,
  output shamd_pkg::cmd_t      cmd_o,
  input  wire shamd_pkg::sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD80,
    ST_PADZ,
    ST_LEN,
    ST_COMP,
    ST_FIN,
    ST_OUT
  } state_e;

  state_e     state_q, state_d;
  state_e     ret_q, ret_d;
  logic [1:0] idx_q, idx_d;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    idx_d   = idx_q;
    cmd_o           = '0;
    cmd_o.src       = shamd_pkg::SRC_DATA;
    cmd_o.vars_load = (state_q != ST_COMP);
    cmd_o.word_idx  = idx_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.shift_en = byte_valid_i;
          cmd_o.count_en = byte_valid_i;
          if (byte_valid_i && sts_i.fill_full) begin
            state_d = ST_COMP;
            ret_d   = last_i ? ST_PAD80 : ST_IDLE;
          end else if (last_i) begin
            state_d = ST_PAD80;
          end
        end
      end
      ST_PAD80: begin
        cmd_o.shift_en = 1'b1;
        cmd_o.src      = shamd_pkg::SRC_PAD;
        if (sts_i.fill_full) begin
          state_d = ST_COMP;
          ret_d   = ST_PADZ;
        end else begin
          state_d = ST_PADZ;
        end
      end
      ST_PADZ: begin
        if (sts_i.fill_len) begin
          state_d = ST_LEN;
        end else begin
          cmd_o.shift_en = 1'b1;
          cmd_o.src      = shamd_pkg::SRC_ZERO;
          if (sts_i.fill_full) begin
            state_d = ST_COMP;
            ret_d   = ST_PADZ;
          end
        end
      end
      ST_LEN: begin
        cmd_o.shift_en = 1'b1;
        cmd_o.src      = shamd_pkg::SRC_LEN;
        if (sts_i.fill_full) begin
          state_d = ST_COMP;
          ret_d   = ST_OUT;
        end
      end
      ST_COMP: begin
        cmd_o.round_en = 1'b1;
        if (sts_i.round_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.hash_add = 1'b1;
        state_d = ret_q;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (idx_q == 2'd3) begin
            cmd_o.hash_init = 1'b1;
            idx_d   = 2'd0;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 2'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      idx_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      idx_q   <= idx_d;
    end
  end

  assign word_index_o = idx_q;
  assign last_word_o  = (idx_q == 2'd3);

endmodule
`default_nettype wire

// ----- design/sha256_message_digest_unit.sv -----
`default_nettype none
// SHA-256 digest of a byte message.
//
// Input channel (in_valid_i / in_stall_o): one request per message byte.
// data_byte_i counts only when byte_valid_i is high; last_i ends the message
// and may come with no byte, so an empty message can be hashed.
// Output channel (out_valid_o / out_stall_i): four 64-bit digest words,
// word_index_o 0..3, first digest byte in the top bits, last_word_o on word 3.
//
// Throughput: a byte is taken every cycle while the block store fills.
// The 64th byte of a block holds the input stalled while the single round
// unit runs the 64 rounds and the result is folded into the hash words.
// After last_i, the 0x80 pad byte, zero bytes up to byte 56 and the 64-bit
// length in bits are shifted in, spilling into a second block when needed;
// each padded block runs the same rounds and fold, then the four words
// follow, one per cycle when the receiver does not stall. Stalling the output
// holds the current word; no new request is taken until word 3 is delivered,
// after which the hash words return to their initial values for the next message.
// Reset clears the control state and loads the initial hash values.
module sha256_message_digest_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        byte_valid_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      digest_word_o,
  output logic [1:0]       word_index_o,
  output logic             last_word_o
);

  shamd_pkg::cmd_t cmd;
  shamd_pkg::sts_t sts;

  // Sequence the fill, pad, compress and drain phases
  shamd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .byte_valid_i (byte_valid_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  // Hold the block window, counters, round unit and hash words
  shamd_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (data_byte_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .digest_word_o (digest_word_o)
  );

`ifndef SYNTHESIS
  // Never take a request while a digest word is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("request taken while digest pending");

  // Delivered non-final word advances to the next word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_word_o) |=>
      (out_valid_o && word_index_o == 2'($past(word_index_o) + 2'd1)))
    else $error("digest word sequence broken");

  // After the final word the block is ready for a new message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_word_o) |=> !in_stall_o)
    else $error("not idle after digest");

  // Rounds never run while bytes are shifted in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.round_en && cmd.shift_en))
    else $error("round and byte shift collide");
`endif

endmodule
`default_nettype wire
